>>> design/det_pkg.sv
// Shared constants, status codes and controller/datapath interface types for the directory table.
`default_nettype none
package det_pkg;

    localparam int TABLE_SLOTS = 32;
    localparam int NAME_BYTES  = 8;
    localparam int NAME_W      = 8 * NAME_BYTES;
    localparam int INODE_W     = 16;
    localparam int LEN_W       = 8;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int PROBE_W     = SLOT_W + 1;
    localparam int OUT_SLOT_W  = 5;
    localparam int ENTRY_W     = NAME_W + INODE_W;

    localparam logic [7:0] CH_QUESTION = 8'd63;
    localparam logic [7:0] CH_BAR      = 8'd124;
    localparam logic [7:0] CH_A        = 8'h61;
    localparam logic [7:0] CH_B        = 8'h62;
    localparam logic [7:0] CH_C        = 8'h63;
    localparam logic [7:0] CH_D        = 8'h64;
    localparam int         PROBE_STEP  = 4;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LONG  = 3'd1,
        ST_ILLEGAL   = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_NO_SPACE  = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    cnt_top;
        logic    cnt_zero;
        logic    cnt_dec;
        logic    cnt_inc;
        logic    probe_step;
        logic    rd;
        logic    wr_probe;
        logic    wr_cnt;
        logic    del;
        logic    out_load;
        t_status status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_delete;
        logic too_long;
        logic illegal;
        logic name_hit;
        logic hit_dup;
        logic cnt_at_zero;
        logic cnt_at_last;
        logic probe_over;
        logic probe_free;
        logic scan_free;
        logic del_hit;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

>>> design/det_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module det_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> design/det_ctrl.sv
// Sequencer for insert and delete: drives datapath commands from its status.
`default_nettype none
module det_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire det_pkg::t_sts i_sts,
    output det_pkg::t_cmd      o_cmd
);
    import det_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_CHECK   = 10'b00_0000_0010,
        S_DUP_RD  = 10'b00_0000_0100,
        S_DUP_CMP = 10'b00_0000_1000,
        S_PROBE   = 10'b00_0001_0000,
        S_SCAN    = 10'b00_0010_0000,
        S_DEL_RD  = 10'b00_0100_0000,
        S_DEL_CMP = 10'b00_1000_0000,
        S_FINISH  = 10'b01_0000_0000,
        S_SPARE   = 10'b10_0000_0000
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.is_delete) begin
                    o_cmd.cnt_zero = 1'b1;
                    n_state        = S_DEL_RD;
                end else if (i_sts.too_long) begin
                    n_status = ST_TOO_LONG;
                    n_state  = S_FINISH;
                end else if (i_sts.illegal) begin
                    n_status = ST_ILLEGAL;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.cnt_top = 1'b1;
                    n_state       = S_DUP_RD;
                end
            end
            S_DUP_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DUP_CMP;
            end
            S_DUP_CMP: begin
                // Highest matching slot decides; scan runs top down.
                if (i_sts.name_hit) begin
                    if (i_sts.hit_dup) begin
                        n_status = ST_DUPLICATE;
                        n_state  = S_FINISH;
                    end else begin
                        n_state = S_PROBE;
                    end
                end else if (i_sts.cnt_at_zero) begin
                    n_state = S_PROBE;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DUP_RD;
                end
            end
            S_PROBE: begin
                if (i_sts.probe_over) begin
                    o_cmd.cnt_top = 1'b1;
                    n_state       = S_SCAN;
                end else if (i_sts.probe_free) begin
                    o_cmd.wr_probe = 1'b1;
                    n_status       = ST_OK;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.probe_step = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_free) begin
                    o_cmd.wr_cnt = 1'b1;
                    n_status     = ST_OK;
                    n_state      = S_FINISH;
                end else if (i_sts.cnt_at_zero) begin
                    n_status = ST_NO_SPACE;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                end
            end
            S_DEL_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DEL_CMP;
            end
            S_DEL_CMP: begin
                if (i_sts.del_hit) begin
                    o_cmd.del = 1'b1;
                    n_status  = ST_OK;
                    n_state   = S_FINISH;
                end else if (i_sts.cnt_at_last) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_DEL_RD;
                end
            end
            S_FINISH: begin
                // Hold until the output register can take the word.
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> design/det_dp.sv
// Datapath: input capture, name checks, slot-used flags, entry RAM, counters, output register.
`default_nettype none
module det_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire det_pkg::t_cmd                i_cmd,
    output det_pkg::t_sts                     o_sts,
    input  wire logic                         i_operation,
    input  wire logic [det_pkg::NAME_W-1:0]   i_entry_name,
    input  wire logic [det_pkg::LEN_W-1:0]    i_name_length,
    input  wire logic [det_pkg::INODE_W-1:0]  i_inode_number,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [2:0]                        o_status,
    output logic [det_pkg::OUT_SLOT_W-1:0]    o_slot_index
);
    import det_pkg::*;

    logic                   r_op;
    logic [NAME_W-1:0]      r_name;
    logic [INODE_W-1:0]     r_inode;
    logic                   r_too_long;
    logic                   r_illegal;
    logic [PROBE_W-1:0]     r_probe;
    logic [SLOT_W-1:0]      r_cnt;
    logic [SLOT_W-1:0]      r_slot;
    logic [TABLE_SLOTS-1:0] r_used;
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [OUT_SLOT_W-1:0]  r_out_slot;

    // Name trim and character check on the incoming word.
    logic [NAME_W-1:0] trim_name;
    logic              trim_illegal;
    logic              alive;
    logic [7:0]        cur_byte;
    logic [PROBE_W-1:0] probe_start;

    always_comb begin
        trim_name    = '0;
        trim_illegal = 1'b0;
        alive        = 1'b1;
        cur_byte     = '0;
        for (int k = 0; k < NAME_BYTES; k++) begin
            cur_byte = i_entry_name[8*k +: 8];
            if (cur_byte == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                trim_name[8*k +: 8] = cur_byte;
                if (cur_byte == CH_QUESTION || cur_byte == CH_BAR) begin
                    trim_illegal = 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (i_entry_name[7:0])
            CH_A:    probe_start = PROBE_W'(0);
            CH_B:    probe_start = PROBE_W'(1);
            CH_C:    probe_start = PROBE_W'(2);
            CH_D:    probe_start = PROBE_W'(3);
            default: probe_start = PROBE_W'(4);
        endcase
    end

    // Entry RAM: {inode, name}; a slot not in use reads as all zero.
    logic [ENTRY_W-1:0] rd_entry;
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic [SLOT_W-1:0]  probe_slot;

    assign probe_slot = r_probe[SLOT_W-1:0];
    assign ram_we     = i_cmd.wr_probe | i_cmd.wr_cnt;
    assign ram_waddr  = i_cmd.wr_probe ? probe_slot : r_cnt;

    det_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_inode, r_name}),
        .i_re    (i_cmd.rd),
        .i_raddr (r_cnt),
        .o_rdata (rd_entry)
    );

    logic               cnt_used;
    logic [NAME_W-1:0]  eff_name;
    logic [INODE_W-1:0] eff_inode;

    assign cnt_used  = r_used[r_cnt];
    assign eff_name  = cnt_used ? rd_entry[NAME_W-1:0] : '0;
    assign eff_inode = cnt_used ? rd_entry[NAME_W +: INODE_W] : '0;

    always_comb begin
        o_sts             = '0;
        o_sts.is_delete   = r_op;
        o_sts.too_long    = r_too_long;
        o_sts.illegal     = r_illegal;
        o_sts.name_hit    = (eff_name == r_name);
        o_sts.hit_dup     = !cnt_used || (eff_inode != '0);
        o_sts.cnt_at_zero = (r_cnt == '0);
        o_sts.cnt_at_last = (r_cnt == SLOT_W'(TABLE_SLOTS - 1));
        o_sts.probe_over  = (r_probe >= PROBE_W'(TABLE_SLOTS));
        o_sts.probe_free  = !r_used[probe_slot];
        o_sts.scan_free   = !cnt_used;
        o_sts.del_hit     = cnt_used && (eff_inode == r_inode);
        o_sts.out_busy    = r_out_valid && i_out_stall;
    end

    // Capture, counters and result slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_operation;
            r_name     <= trim_name;
            r_inode    <= i_inode_number;
            r_too_long <= (i_name_length > LEN_W'(NAME_BYTES));
            r_illegal  <= trim_illegal;
            r_probe    <= probe_start;
        end else if (i_cmd.probe_step) begin
            r_probe <= r_probe + PROBE_W'(PROBE_STEP);
        end

        if (i_cmd.cnt_top) begin
            r_cnt <= SLOT_W'(TABLE_SLOTS - 1);
        end else if (i_cmd.cnt_zero) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_dec) begin
            r_cnt <= r_cnt - SLOT_W'(1);
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + SLOT_W'(1);
        end

        if (i_cmd.wr_probe) begin
            r_slot <= probe_slot;
        end else if (i_cmd.wr_cnt || i_cmd.del) begin
            r_slot <= r_cnt;
        end
    end

    // Slot-used flags; clearing a flag frees the slot, and its entry then reads as all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (ram_we) begin
            r_used[ram_waddr] <= 1'b1;
        end else if (i_cmd.del) begin
            r_used[r_cnt] <= 1'b0;
        end
    end

    // Output register.
    logic [SLOT_W+OUT_SLOT_W-1:0] slot_ext;
    assign slot_ext = {{OUT_SLOT_W{1'b0}}, r_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.status;
            r_out_slot   <= (i_cmd.status == ST_OK) ? slot_ext[OUT_SLOT_W-1:0] : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot_index = r_out_slot;

endmodule
`default_nettype wire

>>> design/directory_entry_table_top.sv
// Top level of the directory entry table: controller plus datapath.
//
//  channel | direction | handshake                | word fields
//  --------+-----------+--------------------------+---------------------------------------
//  in      | to block  | i_in_valid / o_in_stall  | operation, entry_name, name_length,
//          |           |                          | inode_number
//  out     | from block| o_out_valid / i_out_stall| status, slot_index
//
// One word in at a time; each produces one result word.
// Insert: accept and check the word, read and compare each slot of the entry RAM top
// down for a duplicate, probe the used flags in steps of PROBE_STEP, scan the flags
// top down for a free slot if the probe runs past the table, then load the result.
// Delete: read and compare each slot of the entry RAM bottom up, then load the result.
// The single read port of the entry RAM paces both scans.
// Reset (synchronous, active low) frees every slot at once; no clearing pass.
// A result waiting under i_out_stall holds the output register; the next word is
// still taken and worked on, and its result waits until the register frees up.
`default_nettype none
module directory_entry_table_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_operation,
    input  wire logic [det_pkg::NAME_W-1:0]   i_entry_name,
    input  wire logic [det_pkg::LEN_W-1:0]    i_name_length,
    input  wire logic [det_pkg::INODE_W-1:0]  i_inode_number,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [2:0]                        o_status,
    output logic [det_pkg::OUT_SLOT_W-1:0]    o_slot_index
);
    import det_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequence the lookups and writes.
    det_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold the table, the counters and the result word.
    det_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_operation    (i_operation),
        .i_entry_name   (i_entry_name),
        .i_name_length  (i_name_length),
        .i_inode_number (i_inode_number),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index)
    );

endmodule
`default_nettype wire
